@@ src/dstwr_pkg.sv @@
// Shared types, codes and constants of the double-sided two-way ranging engine.
package dstwr_pkg;

    localparam int PEER_COUNT_DEF = 16;
    localparam int STAMP_BITS_DEF = 40;

    localparam int PEER_W   = 4;
    localparam int TIME_W   = 40;
    localparam int FLIGHT_W = 48;
    localparam int DIST_W   = 32;
    localparam int MM_W     = 32;
    localparam int FRAC_W   = 8;

    localparam int IN_TDATA_W  = 128;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 208;
    localparam int OUT_TUSER_W = 4;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 40;

    localparam logic [CFG_INDEX_W-1:0] REG_ANSWER_DELAY = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MM_PER_TICK  = 1'd1;

    localparam logic [TIME_W-1:0] ANSWER_DELAY_RST = '0;
    localparam logic [MM_W-1:0]   MM_PER_TICK_RST  = 32'd78709919;

    localparam logic OP_TX = 1'b0;
    localparam logic OP_RX = 1'b1;

    localparam logic [1:0] FK_PING     = 2'd0;
    localparam logic [1:0] FK_ANCHOR   = 2'd1;
    localparam logic [1:0] FK_BEACON   = 2'd2;
    localparam logic [1:0] FK_TRANSFER = 2'd3;

    localparam logic [1:0] ACT_ANSWER   = 2'd0;
    localparam logic [1:0] ACT_TRANSFER = 2'd1;
    localparam logic [1:0] ACT_RESULT   = 2'd2;

    localparam logic AK_ANCHOR = 1'b0;
    localparam logic AK_BEACON = 1'b1;

    // Stamp slots of one peer row: three initiator stamps, then three responder stamps.
    localparam int SLOTS   = 6;
    localparam int SLOT_I0 = 0;
    localparam int SLOT_I1 = 1;
    localparam int SLOT_I2 = 2;
    localparam int SLOT_R0 = 3;
    localparam int SLOT_R1 = 4;
    localparam int SLOT_R2 = 5;

    typedef struct packed {
        logic [1:0]                 action;
        logic [PEER_W-1:0]          target;
        logic                       answer_kind;
        logic [TIME_W-1:0]          send_time;
        logic [TIME_W-1:0]          reply_interval;
        logic [TIME_W-1:0]          round_interval;
        logic signed [FLIGHT_W-1:0] flight_time_q8;
        logic signed [DIST_W-1:0]   distance_mm;
        logic                       divide_error;
    } t_result;

    typedef struct packed {
        logic busy;
        logic div_error;
    } t_tof_stat;

endpackage

@@ src/ds_twr_ranging_engine_unit.sv @@
// Top level of the double-sided two-way ranging engine.
//
// Radio transmit-done and receive-done events enter on the slave stream; delayed-answer
// commands, transfer commands and ranging results leave on the master stream through an
// output register, so a new event is taken while a result still waits. An event that
// only updates timestamps, or that asks for an answer or a transfer frame, is handled
// as a transfer with row read, then a row update; an answer or transfer request waits
// for a free output register before its update. A received transfer frame runs the
// time-of-flight unit: two 64x16 multiply passes, a bit-serial division of 2*STAMP_BITS+8
// quotient bits, rounding and a distance multiply. Timestamps sit in a
// per-peer row memory whose valid bits clear at reset, so no clearing pass is needed.
module ds_twr_ranging_engine_unit #(
    parameter int PEER_COUNT = dstwr_pkg::PEER_COUNT_DEF,
    parameter int STAMP_BITS = dstwr_pkg::STAMP_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // peer[3:0], event_time[43:4], peer_reply_time[83:44], peer_round_time[123:84]
    input  logic [dstwr_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // opcode[0], frame_kind[2:1]
    input  logic [dstwr_pkg::IN_TUSER_W-1:0]      i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // target[3:0], send_time[43:4], reply_interval[83:44], round_interval[123:84],
    // flight_time_q8[171:124], distance_mm[203:172]
    output logic [dstwr_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // action[1:0], answer_kind[2], divide_error[3]
    output logic [dstwr_pkg::OUT_TUSER_W-1:0]     o_m_axis_tuser,
    input  logic                                  i_cfg_we,
    input  logic [dstwr_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [dstwr_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    localparam int ADDR_W = $clog2(PEER_COUNT);
    localparam int PX_W   = ((ADDR_W > dstwr_pkg::PEER_W) ? ADDR_W : dstwr_pkg::PEER_W) + 1;
    localparam int SB     = STAMP_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_TOF  = 2'd2;

    logic [1:0]                        r_state, n_state;
    logic                              r_op;
    logic [1:0]                        r_kind;
    logic [dstwr_pkg::PEER_W-1:0]      r_peer;
    logic [ADDR_W-1:0]                 r_addr;
    logic [SB-1:0]                     r_t, r_reply, r_round;
    logic [dstwr_pkg::TIME_W-1:0]      r_answer_delay;
    logic [dstwr_pkg::MM_W-1:0]        r_mm;
    dstwr_pkg::t_result                r_out;
    logic                              r_out_valid;

    logic                              in_op;
    logic [1:0]                        in_kind;
    logic [dstwr_pkg::PEER_W-1:0]      in_peer;
    logic [PX_W-1:0]                   peer_ext;
    logic                              peer_ok;
    logic                              relevant;
    logic                              accept;
    logic                              out_free;
    logic                              out_load;
    logic                              mem_wr;
    logic                              tof_start;
    logic [dstwr_pkg::SLOTS-1:0][SB-1:0] rd_row, wr_row;
    logic [SB-1:0]                     tof_round1, tof_reply2;
    dstwr_pkg::t_result                res;
    dstwr_pkg::t_tof_stat              tof_stat;
    logic signed [dstwr_pkg::FLIGHT_W-1:0] tof_flight;
    logic signed [dstwr_pkg::DIST_W-1:0]   tof_distance;

    assign in_op    = i_s_axis_tuser[0];
    assign in_kind  = i_s_axis_tuser[2:1];
    assign in_peer  = i_s_axis_tdata[3:0];
    assign peer_ext = PX_W'(in_peer);
    assign peer_ok  = (peer_ext < PX_W'(PEER_COUNT));
    assign relevant = peer_ok &&
                      !(in_op == dstwr_pkg::OP_TX && in_kind == dstwr_pkg::FK_TRANSFER);

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    assign tof_round1 = rd_row[dstwr_pkg::SLOT_I1] - rd_row[dstwr_pkg::SLOT_I0];
    assign tof_reply2 = rd_row[dstwr_pkg::SLOT_I2] - rd_row[dstwr_pkg::SLOT_I1];

    always_comb begin
        n_state     = r_state;
        wr_row      = rd_row;
        mem_wr      = 1'b0;
        out_load    = 1'b0;
        tof_start   = 1'b0;
        res         = '0;
        res.target  = r_peer;
        case (r_state)
            ST_IDLE: begin
                if (accept && relevant) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_op == dstwr_pkg::OP_TX) begin
                    case (r_kind)
                        dstwr_pkg::FK_PING:   wr_row[dstwr_pkg::SLOT_I0] = r_t;
                        dstwr_pkg::FK_ANCHOR: wr_row[dstwr_pkg::SLOT_R1] = r_t;
                        dstwr_pkg::FK_BEACON: wr_row[dstwr_pkg::SLOT_I2] = r_t;
                        default:              wr_row = rd_row;
                    endcase
                    mem_wr  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    case (r_kind)
                        dstwr_pkg::FK_PING: begin
                            wr_row[dstwr_pkg::SLOT_R0] = r_t;
                            res.answer_kind = dstwr_pkg::AK_ANCHOR;
                            res.send_time   = dstwr_pkg::TIME_W'(r_t + SB'(r_answer_delay));
                        end
                        dstwr_pkg::FK_ANCHOR: begin
                            wr_row[dstwr_pkg::SLOT_I1] = r_t;
                            res.answer_kind = dstwr_pkg::AK_BEACON;
                            res.send_time   = dstwr_pkg::TIME_W'(r_t + SB'(r_answer_delay));
                        end
                        dstwr_pkg::FK_BEACON: begin
                            wr_row[dstwr_pkg::SLOT_R2] = r_t;
                            res.action         = dstwr_pkg::ACT_TRANSFER;
                            res.reply_interval = dstwr_pkg::TIME_W'(
                                rd_row[dstwr_pkg::SLOT_R1] - rd_row[dstwr_pkg::SLOT_R0]);
                            res.round_interval = dstwr_pkg::TIME_W'(
                                r_t - rd_row[dstwr_pkg::SLOT_R1]);
                        end
                        default: begin
                            res.action = dstwr_pkg::ACT_RESULT;
                        end
                    endcase
                    if (r_kind == dstwr_pkg::FK_TRANSFER) begin
                        tof_start = 1'b1;
                        n_state   = ST_TOF;
                    end else if (out_free) begin
                        mem_wr   = 1'b1;
                        out_load = 1'b1;
                        n_state  = ST_IDLE;
                    end
                end
            end
            ST_TOF: begin
                res.action         = dstwr_pkg::ACT_RESULT;
                res.flight_time_q8 = tof_flight;
                res.distance_mm    = tof_distance;
                res.divide_error   = tof_stat.div_error;
                if (!tof_stat.busy && out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_out_valid    <= 1'b0;
            r_answer_delay <= dstwr_pkg::ANSWER_DELAY_RST;
            r_mm           <= dstwr_pkg::MM_PER_TICK_RST;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    dstwr_pkg::REG_ANSWER_DELAY: r_answer_delay <= i_cfg_wdata;
                    dstwr_pkg::REG_MM_PER_TICK:  r_mm <= i_cfg_wdata[dstwr_pkg::MM_W-1:0];
                    default:                     r_mm <= r_mm;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= in_op;
            r_kind  <= in_kind;
            r_peer  <= in_peer;
            r_addr  <= peer_ext[ADDR_W-1:0];
            r_t     <= SB'(i_s_axis_tdata[43:4]);
            r_reply <= SB'(i_s_axis_tdata[83:44]);
            r_round <= SB'(i_s_axis_tdata[123:84]);
        end
        if (out_load) begin
            r_out <= res;
        end
    end

    dstwr_stamp_mem #(
        .PEER_COUNT (PEER_COUNT),
        .STAMP_BITS (STAMP_BITS)
    ) u_stamp_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept && relevant),
        .i_rd_addr (peer_ext[ADDR_W-1:0]),
        .o_rd_row  (rd_row),
        .i_wr_en   (mem_wr),
        .i_wr_addr (r_addr),
        .i_wr_row  (wr_row)
    );

    dstwr_tof_unit #(
        .STAMP_BITS (STAMP_BITS)
    ) u_tof_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (tof_start),
        .i_round1   (tof_round1),
        .i_reply2   (tof_reply2),
        .i_reply1   (r_reply),
        .i_round2   (r_round),
        .i_mm       (r_mm),
        .o_stat     (tof_stat),
        .o_flight   (tof_flight),
        .o_distance (tof_distance)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0, r_out.distance_mm, r_out.flight_time_q8,
                              r_out.round_interval, r_out.reply_interval,
                              r_out.send_time, r_out.target};
    assign o_m_axis_tuser  = {r_out.divide_error, r_out.answer_kind, r_out.action};

`ifndef NO_ASSERTIONS
    a_ready_tof_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !tof_stat.busy)
        else $error("input taken while the flight-time unit is busy");

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tof_start |-> !tof_stat.busy)
        else $error("flight-time unit started while busy");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || i_m_axis_tready))
        else $error("pending result overwritten");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.divide_error) |->
            (r_out.flight_time_q8 == '0 && r_out.distance_mm == '0))
        else $error("divide error with nonzero result");
`endif

endmodule

@@ src/dstwr_stamp_mem.sv @@
// Per-peer timestamp store with one valid bit per row; an unwritten row reads as zero.
module dstwr_stamp_mem #(
    parameter int PEER_COUNT = dstwr_pkg::PEER_COUNT_DEF,
    parameter int STAMP_BITS = dstwr_pkg::STAMP_BITS_DEF
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_rd_en,
    input  logic [$clog2(PEER_COUNT)-1:0]                     i_rd_addr,
    output logic [dstwr_pkg::SLOTS-1:0][STAMP_BITS-1:0]       o_rd_row,
    input  logic                                              i_wr_en,
    input  logic [$clog2(PEER_COUNT)-1:0]                     i_wr_addr,
    input  logic [dstwr_pkg::SLOTS-1:0][STAMP_BITS-1:0]       i_wr_row
);

    logic [dstwr_pkg::SLOTS-1:0][STAMP_BITS-1:0] r_mem [PEER_COUNT];
    logic [dstwr_pkg::SLOTS-1:0][STAMP_BITS-1:0] r_rd_data;
    logic [PEER_COUNT-1:0]                       r_row_valid;
    logic                                        r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_row;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_row_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_row = r_rd_valid ? r_rd_data : '0;

endmodule

@@ src/dstwr_tof_unit.sv @@
// Sequenced time-of-flight unit: shared 64x16 multiplier, bit-serial divider and rounding.
module dstwr_tof_unit #(
    parameter int STAMP_BITS = dstwr_pkg::STAMP_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [STAMP_BITS-1:0]                 i_round1,
    input  logic [STAMP_BITS-1:0]                 i_reply2,
    input  logic [STAMP_BITS-1:0]                 i_reply1,
    input  logic [STAMP_BITS-1:0]                 i_round2,
    input  logic [dstwr_pkg::MM_W-1:0]            i_mm,
    output dstwr_pkg::t_tof_stat                  o_stat,
    output logic signed [dstwr_pkg::FLIGHT_W-1:0] o_flight,
    output logic signed [dstwr_pkg::DIST_W-1:0]   o_distance
);

    localparam int PROD_W     = 2 * STAMP_BITS;
    localparam int QW         = PROD_W + dstwr_pkg::FRAC_W;
    localparam int DEN_W      = STAMP_BITS + 2;
    localparam int REM_W      = STAMP_BITS + 3;
    localparam int CNT_W      = $clog2(QW + 1);
    localparam int DIG_W      = 16;
    localparam int MUL_DIGITS = 3;
    localparam int MB_W       = DIG_W * MUL_DIGITS;
    localparam int MA_W       = 64;
    localparam int ACC_W      = MA_W + MB_W;
    localparam int DQ_W       = 63;
    localparam int DPROD_W    = DQ_W + dstwr_pkg::MM_W;
    localparam int DSUM_W     = DPROD_W + 1;
    localparam int FW         = dstwr_pkg::FLIGHT_W;
    localparam int DW         = dstwr_pkg::DIST_W;

    localparam logic [DSUM_W-1:0] DIST_HALF = DSUM_W'(1) << 31;
    localparam logic [FW-1:0] FLIGHT_POS_LIM = {1'b0, {(FW-1){1'b1}}};
    localparam logic [FW-1:0] FLIGHT_NEG_LIM = {1'b1, {(FW-1){1'b0}}};
    localparam logic [DW-1:0] DIST_POS_LIM   = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] DIST_NEG_LIM   = {1'b1, {(DW-1){1'b0}}};

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_MUL  = 3'd1;
    localparam logic [2:0] T_SUB  = 3'd2;
    localparam logic [2:0] T_ABS  = 3'd3;
    localparam logic [2:0] T_DIV  = 3'd4;
    localparam logic [2:0] T_RND  = 3'd5;
    localparam logic [2:0] T_DIST = 3'd6;

    localparam logic [1:0] PH_ROUND = 2'd0;
    localparam logic [1:0] PH_REPLY = 2'd1;
    localparam logic [1:0] PH_DIST  = 2'd2;

    logic [2:0]                 r_state, n_state;
    logic [1:0]                 r_phase;
    logic [CNT_W-1:0]           r_cnt;
    logic [STAMP_BITS-1:0]      r_round1, r_reply1, r_reply2;
    logic [DEN_W-1:0]           r_den;
    logic [MB_W-1:0]            r_b;
    logic [MA_W+DIG_W-1:0]      r_prod;
    logic [ACC_W-1:0]           r_acc;
    logic [PROD_W-1:0]          r_prod_a;
    logic [PROD_W:0]            r_diff;
    logic                       r_neg;
    logic [QW-1:0]              r_num;
    logic [REM_W-1:0]           r_rem;
    logic                       r_dsat;
    logic                       r_div_err;
    logic signed [FW-1:0]       r_flight;
    logic signed [DW-1:0]       r_distance;

    logic [DEN_W-1:0]  den;
    logic              den_zero;
    logic [MA_W-1:0]   mul_a;
    logic [DIG_W-1:0]  digit;
    logic [ACC_W-1:0]  acc_next;
    logic              mul_last;
    logic              mul_issue;
    logic [REM_W-1:0]  rem_sh;
    logic              rem_ge;
    logic              div_last;
    logic [PROD_W-1:0] mag;
    logic              round_up;
    logic [QW-1:0]     q_rnd;
    logic [FW-1:0]     f_lim, f_mag, f_val;
    logic [DSUM_W-1:0] d_sum;
    logic [63:0]       d_scaled;
    logic [DW-1:0]     d_lim, d_mag, d_val;

    always_comb begin
        den = DEN_W'(i_round1) + DEN_W'(i_round2) + DEN_W'(i_reply1) + DEN_W'(i_reply2);
        den_zero = (den == '0);
        case (r_phase)
            PH_ROUND: mul_a = MA_W'(r_round1);
            PH_REPLY: mul_a = MA_W'(r_reply1);
            default:  mul_a = MA_W'(r_num[DQ_W-1:0]);
        endcase
        digit     = r_b[MB_W-1 -: DIG_W];
        acc_next  = {r_acc[ACC_W-DIG_W-1:0], {DIG_W{1'b0}}} + ACC_W'(r_prod);
        mul_last  = (r_cnt == CNT_W'(MUL_DIGITS));
        mul_issue = (r_cnt < CNT_W'(MUL_DIGITS));
        rem_sh    = {r_rem[REM_W-2:0], r_num[QW-1]};
        rem_ge    = (rem_sh >= REM_W'(r_den));
        div_last  = (r_cnt == CNT_W'(QW - 1));
        mag       = r_diff[PROD_W] ? PROD_W'(~r_diff + 1'b1) : r_diff[PROD_W-1:0];
        round_up  = ({r_rem, 1'b0} >= (REM_W + 1)'(r_den));
        q_rnd     = r_num + QW'(round_up);

        f_lim = r_neg ? FLIGHT_NEG_LIM : FLIGHT_POS_LIM;
        f_mag = (r_num > QW'(f_lim)) ? f_lim : r_num[FW-1:0];
        f_val = r_neg ? (~f_mag + 1'b1) : f_mag;

        d_sum    = DSUM_W'(r_acc[DPROD_W-1:0]) + DIST_HALF;
        d_scaled = 64'(d_sum[DSUM_W-1:32]);
        d_lim    = r_neg ? DIST_NEG_LIM : DIST_POS_LIM;
        d_mag    = (r_dsat || d_scaled > 64'(d_lim)) ? d_lim : d_scaled[DW-1:0];
        d_val    = r_neg ? (~d_mag + 1'b1) : d_mag;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            T_IDLE: begin
                if (i_start && !den_zero) begin
                    n_state = T_MUL;
                end
            end
            T_MUL: begin
                if (mul_last) begin
                    case (r_phase)
                        PH_ROUND: n_state = T_MUL;
                        PH_REPLY: n_state = T_SUB;
                        default:  n_state = T_DIST;
                    endcase
                end
            end
            T_SUB:   n_state = T_ABS;
            T_ABS:   n_state = T_DIV;
            T_DIV: begin
                if (div_last) begin
                    n_state = T_RND;
                end
            end
            T_RND:   n_state = T_MUL;
            T_DIST:  n_state = T_IDLE;
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_phase <= PH_ROUND;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                T_IDLE: begin
                    r_phase <= PH_ROUND;
                    r_cnt   <= '0;
                end
                T_MUL: begin
                    if (mul_last) begin
                        r_cnt   <= '0;
                        r_phase <= r_phase + 2'd1;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                T_ABS:   r_cnt <= '0;
                T_DIV:   r_cnt <= r_cnt + 1'b1;
                T_RND: begin
                    r_phase <= PH_DIST;
                    r_cnt   <= '0;
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            T_IDLE: begin
                if (i_start) begin
                    r_round1   <= i_round1;
                    r_reply1   <= i_reply1;
                    r_reply2   <= i_reply2;
                    r_den      <= den;
                    r_b        <= MB_W'(i_round2);
                    r_div_err  <= den_zero;
                    r_flight   <= '0;
                    r_distance <= '0;
                end
            end
            T_MUL: begin
                if (mul_issue) begin
                    r_prod <= mul_a * digit;
                    r_b    <= {r_b[MB_W-DIG_W-1:0], {DIG_W{1'b0}}};
                end
                if (r_cnt == '0) begin
                    r_acc <= '0;
                end else begin
                    r_acc <= acc_next;
                end
                if (r_phase == PH_REPLY && r_cnt == '0) begin
                    r_prod_a <= r_acc[PROD_W-1:0];
                end
                if (mul_last && r_phase == PH_ROUND) begin
                    r_b <= MB_W'(r_reply2);
                end
            end
            T_SUB: begin
                r_diff <= {1'b0, r_prod_a} - {1'b0, r_acc[PROD_W-1:0]};
            end
            T_ABS: begin
                r_neg <= r_diff[PROD_W];
                r_num <= {mag, {dstwr_pkg::FRAC_W{1'b0}}};
                r_rem <= '0;
            end
            T_DIV: begin
                r_rem <= rem_ge ? (rem_sh - REM_W'(r_den)) : rem_sh;
                r_num <= {r_num[QW-2:0], rem_ge};
            end
            T_RND: begin
                r_num  <= q_rnd;
                r_dsat <= |q_rnd[QW-1:DQ_W];
                r_b    <= MB_W'(i_mm);
            end
            T_DIST: begin
                r_flight   <= f_val;
                r_distance <= d_val;
            end
            default: begin
                r_num <= r_num;
            end
        endcase
    end

    assign o_stat.busy      = (r_state != T_IDLE);
    assign o_stat.div_error = r_div_err;
    assign o_flight         = r_flight;
    assign o_distance       = r_distance;

endmodule
